// File: hdl/htlp_pkg.sv
`default_nettype none

package htlp_pkg;

   localparam int TABLE_SLOTS_DEF = 16;

   localparam int KEY_W      = 32;
   localparam int NAME_LO_W  = 64;
   localparam int NAME_MID_W = 64;
   localparam int NAME_HI_W  = 32;
   localparam int SEL_W      = 4;
   localparam int SLOT_W     = 4;
   localparam int STATUS_W   = 3;

   // remainder pipeline depth
   localparam int HASH_STEPS = 3;
   localparam int HASH_CNT_W = $clog2(HASH_STEPS);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_HOME     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PROBED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd4;

   typedef struct packed {
      logic clr_step;
      logic load_req;
      logic hash_step;
      logic probe_init;
      logic probe_run;
      logic read_issue;
      logic read_stage;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hash_last;
      logic probe_found;
      logic probe_full;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: hdl/htlp_ctrl.sv
`default_nettype none

module htlp_ctrl import htlp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_type,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_PSTART = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_RDISS  = 3'd5;
   localparam logic [2:0] S_RDSTG  = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_type == REQ_READ) ? S_RDISS : S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               state_in = S_PSTART;
            end
         end
         S_PSTART: begin
            cmd.probe_init = 1'b1;
            state_in       = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe_run = 1'b1;
            if (sts.probe_found || sts.probe_full) begin
               state_in = S_FINISH;
            end
         end
         S_RDISS: begin
            cmd.read_issue = 1'b1;
            state_in       = S_RDSTG;
         end
         S_RDSTG: begin
            cmd.read_stage = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/htlp_datapath.sv
`default_nettype none

module htlp_datapath import htlp_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [KEY_W-1:0]      req_record_key,
   input  wire logic [SEL_W-1:0]      req_slot_select,
   input  wire logic [NAME_LO_W-1:0]  req_name_bytes_lo,
   input  wire logic [NAME_MID_W-1:0] req_name_bytes_mid,
   input  wire logic [NAME_HI_W-1:0]  req_name_bytes_hi,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot_index,
   output logic [KEY_W-1:0]           rsp_out_key,
   output logic [NAME_LO_W-1:0]       rsp_out_name_lo,
   output logic [NAME_MID_W-1:0]      rsp_out_name_mid,
   output logic [NAME_HI_W-1:0]       rsp_out_name_hi
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int REM_W = IDX_W + 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

   localparam logic [REM_W-1:0] SLOTS_R    = REM_W'(TABLE_SLOTS);
   localparam logic [CNT_W-1:0] SLOTS_C    = CNT_W'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [HASH_CNT_W-1:0] LAST_HASH = HASH_CNT_W'(HASH_STEPS - 1);
   localparam logic [KEY_W-1:0] RECIP      = KEY_W'((64'd1 << KEY_W) / TABLE_SLOTS);
   localparam logic [KEY_W-1:0] SLOTS_K    = KEY_W'(TABLE_SLOTS);

   typedef struct packed {
      logic                  valid;
      logic [KEY_W-1:0]      key;
      logic [NAME_LO_W-1:0]  name_lo;
      logic [NAME_MID_W-1:0] name_mid;
      logic [NAME_HI_W-1:0]  name_hi;
   } entry_type;

   entry_type mem [TABLE_SLOTS];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;

   logic [KEY_W-1:0]      key_ff;
   logic [SEL_W-1:0]      sel_ff;
   logic [NAME_LO_W-1:0]  name_lo_ff;
   logic [NAME_MID_W-1:0] name_mid_ff;
   logic [NAME_HI_W-1:0]  name_hi_ff;

   logic [2*KEY_W-1:0]    prod;
   logic [KEY_W-1:0]      quot_ff;
   logic [KEY_W-1:0]      quot_in;
   logic [REM_W-1:0]      diff_ff;
   logic [REM_W-1:0]      diff_in;
   logic [IDX_W-1:0]      rem_ff;
   logic [IDX_W-1:0]      rem_in;
   logic [HASH_CNT_W-1:0] hash_cnt_ff;

   logic [IDX_W-1:0] clr_ff;
   logic [IDX_W-1:0] clr_in;

   logic [IDX_W-1:0] probe_addr_ff;
   logic [IDX_W-1:0] probe_addr_nxt;
   logic [CNT_W-1:0] probe_cnt_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] chk_addr_ff;
   logic             chk_home_ff;
   logic             issue_ok;
   logic             found;
   logic             full;
   logic             in_range;
   logic             occupied;

   logic [STATUS_W-1:0] fin_status_ff;
   logic [SLOT_W-1:0]   fin_slot_ff;
   logic                fin_data_ok_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [KEY_W-1:0]      rsp_key_ff;
   logic [NAME_LO_W-1:0]  rsp_name_lo_ff;
   logic [NAME_MID_W-1:0] rsp_name_mid_ff;
   logic [NAME_HI_W-1:0]  rsp_name_hi_ff;

   // key mod table size: reciprocal estimate, multiply-subtract, one correcting subtract
   always_comb begin
      prod    = {{KEY_W{1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
      quot_in = prod[2*KEY_W-1:KEY_W];
      diff_in = REM_W'(key_ff - quot_ff * SLOTS_K);
      rem_in  = (diff_ff >= SLOTS_R) ? IDX_W'(diff_ff - SLOTS_R) : diff_ff[IDX_W-1:0];
   end

   assign clr_in         = clr_ff + 1'b1;
   assign probe_addr_nxt = (probe_addr_ff == LAST_IDX) ? '0 : probe_addr_ff + 1'b1;
   assign issue_ok       = (probe_cnt_ff != SLOTS_C);
   assign found          = pend_ff && !rd_data_ff.valid;
   assign full           = pend_ff && rd_data_ff.valid && !issue_ok;
   assign in_range       = (KEY_W'(sel_ff) < KEY_W'(TABLE_SLOTS));
   assign occupied       = in_range && rd_data_ff.valid;

   assign sts.clr_last    = (clr_ff == LAST_IDX);
   assign sts.hash_last   = (hash_cnt_ff == LAST_HASH);
   assign sts.probe_found = found;
   assign sts.probe_full  = full;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   // table memory
   always_comb begin
      wr_data.valid    = !cmd.clr_step;
      wr_data.key      = cmd.clr_step ? '0 : key_ff;
      wr_data.name_lo  = cmd.clr_step ? '0 : name_lo_ff;
      wr_data.name_mid = cmd.clr_step ? '0 : name_mid_ff;
      wr_data.name_hi  = cmd.clr_step ? '0 : name_hi_ff;
      mem_we    = cmd.clr_step || (cmd.probe_run && found);
      mem_waddr = cmd.clr_step ? clr_ff : chk_addr_ff;
      mem_re    = cmd.read_issue || (cmd.probe_run && issue_ok);
      mem_raddr = cmd.read_issue ? IDX_W'(sel_ff) : probe_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // request capture and hash
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff      <= req_record_key;
         sel_ff      <= req_slot_select;
         name_lo_ff  <= req_name_bytes_lo;
         name_mid_ff <= req_name_bytes_mid;
         name_hi_ff  <= req_name_bytes_hi;
         hash_cnt_ff <= '0;
      end else if (cmd.hash_step) begin
         quot_ff     <= quot_in;
         diff_ff     <= diff_in;
         rem_ff      <= rem_in;
         hash_cnt_ff <= hash_cnt_ff + 1'b1;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_in;
      end
   end

   // probe: one read issued per cycle, each slot checked from the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.probe_init) begin
         probe_addr_ff <= rem_ff;
         probe_cnt_ff  <= '0;
         pend_ff       <= 1'b0;
      end else if (cmd.probe_run) begin
         pend_ff <= issue_ok;
         if (issue_ok) begin
            probe_addr_ff <= probe_addr_nxt;
            probe_cnt_ff  <= probe_cnt_ff + 1'b1;
            chk_addr_ff   <= probe_addr_ff;
            chk_home_ff   <= (probe_cnt_ff == '0);
         end
      end
   end

   // result staging
   always_ff @(posedge clock) begin
      if (cmd.probe_run && found) begin
         fin_status_ff  <= chk_home_ff ? ST_HOME : ST_PROBED;
         fin_slot_ff    <= SLOT_W'(chk_addr_ff);
         fin_data_ok_ff <= 1'b0;
      end else if (cmd.probe_run && full) begin
         fin_status_ff  <= ST_FULL;
         fin_slot_ff    <= '0;
         fin_data_ok_ff <= 1'b0;
      end else if (cmd.read_stage) begin
         fin_status_ff  <= occupied ? ST_OCCUPIED : ST_EMPTY;
         fin_slot_ff    <= sel_ff;
         fin_data_ok_ff <= occupied;
      end
   end

   // output word register
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff   <= fin_status_ff;
         rsp_slot_ff     <= fin_slot_ff;
         rsp_key_ff      <= fin_data_ok_ff ? rd_data_ff.key : '0;
         rsp_name_lo_ff  <= fin_data_ok_ff ? rd_data_ff.name_lo : '0;
         rsp_name_mid_ff <= fin_data_ok_ff ? rd_data_ff.name_mid : '0;
         rsp_name_hi_ff  <= fin_data_ok_ff ? rd_data_ff.name_hi : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_name_lo  = rsp_name_lo_ff;
   assign rsp_out_name_mid = rsp_name_mid_ff;
   assign rsp_out_name_hi  = rsp_name_hi_ff;

endmodule

`default_nettype wire

// File: hdl/hash_table_linear_probe_insert.sv
// Open-addressing hash table of TABLE_SLOTS entries with linear probing. An insert word
// (req_type 0) hashes record_key to key mod TABLE_SLOTS, writes key and 20-byte name into the
// first free slot from there with wrap-around, and answers placed-at-home, placed-after-
// collision or table-full; a read word (req_type 1) returns the contents of one slot, or
// empty. After reset a clearing pass over all TABLE_SLOTS slots runs before the first word is
// taken. An insert probes from 1 to TABLE_SLOTS slots: the key remainder is formed by
// reciprocal multiply, multiply-subtract and one correcting subtract, the probe is started,
// then the table memory (one read and one write port) is read one slot per cycle, each slot
// checked in the cycle after its read. A read word reads its slot, then stages the result.
// One word is in work at a time and the next is taken in the cycle after its result is
// loaded; a finished result waits in the output register while the next word starts.
`default_nettype none

module hash_table_linear_probe_insert import htlp_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [KEY_W-1:0]      req_record_key,
   input  wire logic [SEL_W-1:0]      req_slot_select,
   input  wire logic [NAME_LO_W-1:0]  req_name_bytes_lo,
   input  wire logic [NAME_MID_W-1:0] req_name_bytes_mid,
   input  wire logic [NAME_HI_W-1:0]  req_name_bytes_hi,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot_index,
   output logic [KEY_W-1:0]           rsp_out_key,
   output logic [NAME_LO_W-1:0]       rsp_out_name_lo,
   output logic [NAME_MID_W-1:0]      rsp_out_name_mid,
   output logic [NAME_HI_W-1:0]       rsp_out_name_hi
);

   cmd_type cmd;
   sts_type sts;

   htlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   htlp_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_record_key     (req_record_key),
      .req_slot_select    (req_slot_select),
      .req_name_bytes_lo  (req_name_bytes_lo),
      .req_name_bytes_mid (req_name_bytes_mid),
      .req_name_bytes_hi  (req_name_bytes_hi),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_name_lo    (rsp_out_name_lo),
      .rsp_out_name_mid   (rsp_out_name_mid),
      .rsp_out_name_hi    (rsp_out_name_hi)
   );

endmodule

`default_nettype wire

// File: tb/tb_hash_table_linear_probe_insert.sv
`timescale 1ns / 100ps

module tb_hash_table_linear_probe_insert;
   import htlp_pkg::*;

   localparam int TBL_SLOTS   = TABLE_SLOTS_DEF;
   localparam int DIR_ROWS    = 24;
   localparam int RAND_ITEMS  = 1530;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                  op;
      logic [KEY_W-1:0]      key;
      logic [SEL_W-1:0]      sel;
      logic [NAME_LO_W-1:0]  lo;
      logic [NAME_MID_W-1:0] mid;
      logic [NAME_HI_W-1:0]  hi;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_W-1:0]     slot;
      logic [KEY_W-1:0]      key;
      logic [NAME_LO_W-1:0]  lo;
      logic [NAME_MID_W-1:0] mid;
      logic [NAME_HI_W-1:0]  hi;
   } rsp_word_type;

   typedef struct packed {
      logic         has_fixed;
      req_word_type req;
      rsp_word_type rsp;
   } dir_row_type;

   localparam rsp_word_type NO_RSP = '0;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // empty table
      '{1'b1, '{REQ_READ, 32'h0, 4'd0, 64'h0, 64'h0, 32'h0},
              '{ST_EMPTY, 4'd0, 32'h0, 64'h0, 64'h0, 32'h0}},
      '{1'b1, '{REQ_READ, 32'h0, 4'd15, 64'h0, 64'h0, 32'h0},
              '{ST_EMPTY, 4'd15, 32'h0, 64'h0, 64'h0, 32'h0}},
      '{1'b1, '{REQ_INSERT, 32'h0, 4'd0, 64'h0, 64'h0, 32'h0},
              '{ST_HOME, 4'd0, 32'h0, 64'h0, 64'h0, 32'h0}},
      '{1'b1, '{REQ_INSERT, 32'd16, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
              '{ST_PROBED, 4'd1, 32'h0, 64'h0, 64'h0, 32'h0}},
      '{1'b1, '{REQ_INSERT, 32'hFFFF_FFFF, 4'd9, 64'h0123_4567_89AB_CDEF,
                64'hFEDC_BA98_7654_3210, 32'h5A5A_A5A5},
              '{ST_HOME, 4'd15, 32'h0, 64'h0, 64'h0, 32'h0}},
      // probe wraps from the last slot
      '{1'b0, '{REQ_INSERT, 32'd31, 4'd0, 64'h6F6C_6C65_4820_2020,
                64'h2020_2020_2020_2020, 32'h2020_2020}, NO_RSP},
      '{1'b1, '{REQ_READ, 32'hFFFF_FFFF, 4'd0, 64'h1, 64'h1, 32'h1},
              '{ST_OCCUPIED, 4'd0, 32'h0, 64'h0, 64'h0, 32'h0}},
      '{1'b1, '{REQ_READ, 32'h0, 4'd1, 64'h0, 64'h0, 32'h0},
              '{ST_OCCUPIED, 4'd1, 32'd16, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}},
      '{1'b0, '{REQ_READ, 32'h0, 4'd15, 64'h0, 64'h0, 32'h0}, NO_RSP},
      // duplicate key, name with zero bytes inside
      '{1'b0, '{REQ_INSERT, 32'd16, 4'd0, 64'h0041_0000_4200_0043,
                64'h0000_4400_0000_0045, 32'h4600_0000}, NO_RSP},
      '{1'b0, '{REQ_READ, 32'h0, 4'd3, 64'h0, 64'h0, 32'h0}, NO_RSP},
      // all of these hash to slot 4 and probe ever deeper
      '{1'b0, '{REQ_INSERT, 32'h0000_0004, 4'd0, 64'h11, 64'h12, 32'h13}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'h8000_0014, 4'd0, 64'h21, 64'h22, 32'h23}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'hFFFF_FFF4, 4'd0, 64'h31, 64'h32, 32'h33}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'h1234_5674, 4'd0, 64'h41, 64'h42, 32'h43}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'h7654_3214, 4'd0, 64'h51, 64'h52, 32'h53}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'hDEAD_BEE4, 4'd0, 64'h61, 64'h62, 32'h63}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'h0000_0104, 4'd0, 64'h71, 64'h72, 32'h73}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'hCAFE_0004, 4'd0, 64'h81, 64'h82, 32'h83}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'h5555_5554, 4'd0, 64'h91, 64'h92, 32'h93}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'hAAAA_AAA4, 4'd0, 64'hA1, 64'hA2, 32'hA3}, NO_RSP},
      '{1'b0, '{REQ_INSERT, 32'h0F0F_0F04, 4'd0, 64'hB1, 64'hB2, 32'hB3}, NO_RSP},
      // every slot taken
      '{1'b1, '{REQ_INSERT, 32'h0000_0003, 4'd7, 64'hC1, 64'hC2, 32'hC3},
              '{ST_FULL, 4'd0, 32'h0, 64'h0, 64'h0, 32'h0}},
      '{1'b0, '{REQ_READ, 32'h0, 4'd14, 64'h0, 64'h0, 32'h0}, NO_RSP}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [KEY_W-1:0]      req_record_key;
   logic [SEL_W-1:0]      req_slot_select;
   logic [NAME_LO_W-1:0]  req_name_bytes_lo;
   logic [NAME_MID_W-1:0] req_name_bytes_mid;
   logic [NAME_HI_W-1:0]  req_name_bytes_hi;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic [KEY_W-1:0]      rsp_out_key;
   logic [NAME_LO_W-1:0]  rsp_out_name_lo;
   logic [NAME_MID_W-1:0] rsp_out_name_mid;
   logic [NAME_HI_W-1:0]  rsp_out_name_hi;

   logic                  shadow_valid [TBL_SLOTS];
   logic [KEY_W-1:0]      shadow_key [TBL_SLOTS];
   logic [NAME_LO_W-1:0]  shadow_lo [TBL_SLOTS];
   logic [NAME_MID_W-1:0] shadow_mid [TBL_SLOTS];
   logic [NAME_HI_W-1:0]  shadow_hi [TBL_SLOTS];

   rsp_word_type expected_rsp [$];
   int           fail_cnt = 0;
   int           rsp_seen = 0;
   int           cycle_cnt = 0;

   hash_table_linear_probe_insert u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_record_key     (req_record_key),
      .req_slot_select    (req_slot_select),
      .req_name_bytes_lo  (req_name_bytes_lo),
      .req_name_bytes_mid (req_name_bytes_mid),
      .req_name_bytes_hi  (req_name_bytes_hi),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_name_lo    (rsp_out_name_lo),
      .rsp_out_name_mid   (rsp_out_name_mid),
      .rsp_out_name_hi    (rsp_out_name_hi)
   );

   always #10 clock = ~clock;

   // insert into or read from the shadow table, returning the word the block should answer
   function automatic rsp_word_type probe_shadow_table(input req_word_type w);
      rsp_word_type r;
      int unsigned  home_slot;
      int unsigned  idx;
      r = '0;
      if (w.op == REQ_INSERT) begin
         home_slot = w.key % TBL_SLOTS;
         r.status = ST_FULL;
         for (int i = 0; i < TBL_SLOTS && r.status == ST_FULL; i++) begin
            idx = (home_slot + i) % TBL_SLOTS;
            if (!shadow_valid[idx]) begin
               shadow_valid[idx] = 1'b1;
               shadow_key[idx] = w.key;
               shadow_lo[idx] = w.lo;
               shadow_mid[idx] = w.mid;
               shadow_hi[idx] = w.hi;
               r.status = (i == 0) ? ST_HOME : ST_PROBED;
               r.slot = idx[SLOT_W-1:0];
            end
         end
      end else begin
         r.slot = w.sel;
         if (w.sel < TBL_SLOTS && shadow_valid[w.sel]) begin
            r.status = ST_OCCUPIED;
            r.key = shadow_key[w.sel];
            r.lo = shadow_lo[w.sel];
            r.mid = shadow_mid[w.sel];
            r.hi = shadow_hi[w.sel];
         end else begin
            r.status = ST_EMPTY;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // request side
   initial begin
      req_word_type w;
      rsp_word_type r;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_INSERT;
      req_record_key <= '0;
      req_slot_select <= '0;
      req_name_bytes_lo <= '0;
      req_name_bytes_mid <= '0;
      req_name_bytes_hi <= '0;
      for (int s = 0; s < TBL_SLOTS; s++) shadow_valid[s] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < DIR_ROWS + RAND_ITEMS; n++) begin
         if (n < DIR_ROWS) begin
            w = DIR_TABLE[n].req;
         end else begin
            w.op = $urandom_range(1) ? REQ_READ : REQ_INSERT;
            w.key = $urandom;
            w.sel = SEL_W'($urandom);
            w.lo = {$urandom, $urandom};
            w.mid = {$urandom, $urandom};
            w.hi = $urandom;
         end
         // random gaps between words, with a quiet stretch of no gaps from word 400 to 799
         while ((n < 400 || n >= 800) && $urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_type <= w.op;
         req_record_key <= w.key;
         req_slot_select <= w.sel;
         req_name_bytes_lo <= w.lo;
         req_name_bytes_mid <= w.mid;
         req_name_bytes_hi <= w.hi;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         r = probe_shadow_table(w);
         if (n < DIR_ROWS && DIR_TABLE[n].has_fixed) r = DIR_TABLE[n].rsp;
         expected_rsp.push_back(r);
      end
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_cnt == 0 && expected_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // result side
   initial begin
      rsp_word_type got;
      rsp_word_type want;
      int           hold_left;
      bit           hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_slot_index, rsp_out_key, rsp_out_name_lo,
                   rsp_out_name_mid, rsp_out_name_hi};
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               fail_cnt++;
               if (fail_cnt <= 10)
                  $display("unexpected word: status %0d slot %0d key %h", got.status,
                           got.slot, got.key);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.key !== want.key || got.lo !== want.lo ||
                   got.mid !== want.mid || got.hi !== want.hi) begin
                  fail_cnt++;
                  if (fail_cnt <= 10) begin
                     $display("word %0d exp: status %0d slot %0d key %h name %h %h %h",
                              rsp_seen, want.status, want.slot, want.key, want.lo,
                              want.mid, want.hi);
                     $display("word %0d got: status %0d slot %0d key %h name %h %h %h",
                              rsp_seen, got.status, got.slot, got.key, got.lo,
                              got.mid, got.hi);
                  end
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left == 0 && !hold_done && rsp_seen >= 1000) begin
            hold_left = 250;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (rsp_seen < 400 || rsp_seen >= 800) && ($urandom_range(99) < 6);
         end
      end
   end

endmodule
